/* hw/rtl/stkpal_pkg.sv */
`default_nettype none

package stkpal_pkg;

  localparam int unsigned DepthDefault = 64;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned CountOutWidth = 7;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_QUERY = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_UNDERFLOW = 2'd2
  } status_e;

  // What the output register is loaded with.
  typedef enum logic [2:0] {
    RES_OK,
    RES_OVERFLOW,
    RES_UNDERFLOW,
    RES_POP,
    RES_PAL_TRUE,
    RES_PAL_FALSE
  } res_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_QREAD,
    S_QCMP
  } state_e;

  typedef struct packed {
    logic push;
    logic pop;
    logic q_init;
    logic q_step;
    logic load;
    res_e res;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic count_zero;
    logic count_full;
    logic lo_ge_hi;
    logic pair_match;
  } sts_t;

endpackage

`default_nettype wire

/* hw/rtl/stack_with_palindrome_check_core.sv */
// Sequencing: push, rejected push, rejected pop, empty query and unused opcodes load the
//   result on acceptance; pop loads it in S_POP after a registered RAM read; a query
//   alternates S_QREAD and S_QCMP for each entry pair through the dual-read RAM port.
// Throughput: one transaction in flight; push accepted every cycle while out_free holds.
// Reset: rst_ni is asynchronous, active low; it empties the stack and the output register.
//   Stack RAM contents are not cleared; only written entries are ever read.
`default_nettype none

module stack_with_palindrome_check_core #(
  parameter int unsigned DEPTH = stkpal_pkg::DepthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input transaction
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] push_value
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] opcode
  // Result transaction
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,   // [31:0] popped_value, [32] is_palindrome,
                                           // [39:33] count_now, [40] full_flag,
                                           // [41] empty_flag, [47:42] zero
  output logic [1:0]       m_axis_tuser    // [1:0] status
);

  import stkpal_pkg::*;

  cmd_t cmd;
  sts_t sts;

  logic [ValueWidth-1:0]    popped_value;
  logic                     is_palindrome;
  logic [CountOutWidth-1:0] count_now;
  logic                     full_flag, empty_flag;

  // Controller: decodes the opcode against the stack flags and sequences
  // pops and the pairwise palindrome walk.
  stkpal_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .opcode_i   (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: stack RAM, entry count, query pointers and the output register,
  // which holds a finished result until taken; input waits until it is free or being taken.
  stkpal_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .push_value_i    (s_axis_tdata),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .status_o        (m_axis_tuser),
    .popped_value_o  (popped_value),
    .is_palindrome_o (is_palindrome),
    .count_now_o     (count_now),
    .full_flag_o     (full_flag),
    .empty_flag_o    (empty_flag)
  );

  // Pack the result fields, lowest field first, padded to whole bytes.
  assign m_axis_tdata = {6'b0, empty_flag, full_flag, count_now, is_palindrome, popped_value};

endmodule

`default_nettype wire

/* hw/rtl/stkpal_ram.sv */
`default_nettype none

module stkpal_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr_i,
  input  wire logic [WIDTH-1:0]           wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr_b_i,
  output logic      [WIDTH-1:0]           rdata_a_o,
  output logic      [WIDTH-1:0]           rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

/* hw/rtl/stkpal_ctrl.sv */
`default_nettype none

module stkpal_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic [1:0]        opcode_i,
  output logic                   in_ready_o,
  input  wire stkpal_pkg::sts_t  sts_i,
  output stkpal_pkg::cmd_t       cmd_o
);

  import stkpal_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE) && sts_i.out_free;
  assign accept     = in_ready_o && in_valid_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '{push: 1'b0, pop: 1'b0, q_init: 1'b0, q_step: 1'b0,
                load: 1'b0, res: RES_OK};
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (opcode_i)
            OP_PUSH: begin
              cmd_o.load = 1'b1;
              if (sts_i.count_full) begin
                cmd_o.res = RES_OVERFLOW;
              end else begin
                cmd_o.push = 1'b1;
              end
            end
            OP_POP: begin
              if (sts_i.count_zero) begin
                cmd_o.load = 1'b1;
                cmd_o.res  = RES_UNDERFLOW;
              end else begin
                cmd_o.pop = 1'b1;
                state_d   = S_POP;
              end
            end
            OP_QUERY: begin
              if (sts_i.count_zero) begin
                cmd_o.load = 1'b1;
              end else begin
                cmd_o.q_init = 1'b1;
                state_d      = S_QREAD;
              end
            end
            default: begin
              cmd_o.load = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        cmd_o.load = 1'b1;
        cmd_o.res  = RES_POP;
        state_d    = S_IDLE;
      end
      S_QREAD: begin
        if (sts_i.lo_ge_hi) begin
          cmd_o.load = 1'b1;
          cmd_o.res  = RES_PAL_TRUE;
          state_d    = S_IDLE;
        end else begin
          state_d = S_QCMP;
        end
      end
      S_QCMP: begin
        if (!sts_i.pair_match) begin
          cmd_o.load = 1'b1;
          cmd_o.res  = RES_PAL_FALSE;
          state_d    = S_IDLE;
        end else begin
          cmd_o.q_step = 1'b1;
          state_d      = S_QREAD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/stkpal_dp.sv */
`default_nettype none

module stkpal_dp #(
  parameter int unsigned DEPTH = stkpal_pkg::DepthDefault
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire stkpal_pkg::cmd_t                  cmd_i,
  output stkpal_pkg::sts_t                       sts_o,
  input  wire logic [stkpal_pkg::ValueWidth-1:0] push_value_i,
  input  wire logic                              out_ready_i,
  output logic                                   out_valid_o,
  output logic [1:0]                             status_o,
  output logic [stkpal_pkg::ValueWidth-1:0]      popped_value_o,
  output logic                                   is_palindrome_o,
  output logic [stkpal_pkg::CountOutWidth-1:0]   count_now_o,
  output logic                                   full_flag_o,
  output logic                                   empty_flag_o
);

  import stkpal_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [CW-1:0]         count_q, count_d;
  logic [AW-1:0]         lo_q, lo_d, hi_q, hi_d;
  logic [AW-1:0]         raddr_a;
  logic [ValueWidth-1:0] rdata_a, rdata_b;

  logic                     out_valid_q;
  logic [1:0]               status_q;
  logic [ValueWidth-1:0]    popped_q;
  logic                     pal_q;
  logic [CountOutWidth-1:0] count_out_q;
  logic                     full_q, empty_q;

  stkpal_ram #(
    .WIDTH (ValueWidth),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (cmd_i.push),
    .waddr_i   (AW'(count_q)),
    .wdata_i   (push_value_i),
    .raddr_a_i (raddr_a),
    .raddr_b_i (hi_q),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // A pop reads the current top entry; otherwise port A follows the low query pointer.
  assign raddr_a = cmd_i.pop ? AW'(count_q - 1'b1) : lo_q;

  always_comb begin
    count_d = count_q;
    if (cmd_i.push) begin
      count_d = count_q + 1'b1;
    end else if (cmd_i.pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_comb begin
    lo_d = lo_q;
    hi_d = hi_q;
    if (cmd_i.q_init) begin
      lo_d = '0;
      hi_d = AW'(count_q - 1'b1);
    end else if (cmd_i.q_step) begin
      lo_d = lo_q + 1'b1;
      hi_d = hi_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cmd_i.load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d;
    hi_q <= hi_d;
    if (cmd_i.load) begin
      status_q    <= STAT_OK;
      popped_q    <= '0;
      pal_q       <= 1'b0;
      count_out_q <= CountOutWidth'(count_d);
      full_q      <= (count_d == CW'(DEPTH));
      empty_q     <= (count_d == '0);
      case (cmd_i.res)
        RES_OVERFLOW:  status_q <= STAT_OVERFLOW;
        RES_UNDERFLOW: status_q <= STAT_UNDERFLOW;
        RES_POP:       popped_q <= rdata_a;
        RES_PAL_TRUE:  pal_q    <= 1'b1;
        default:       ;
      endcase
    end
  end

  assign sts_o.out_free   = !out_valid_q || out_ready_i;
  assign sts_o.count_zero = (count_q == '0);
  assign sts_o.count_full = (count_q == CW'(DEPTH));
  assign sts_o.lo_ge_hi   = (lo_q >= hi_q);
  assign sts_o.pair_match = (rdata_a == rdata_b);

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign popped_value_o  = popped_q;
  assign is_palindrome_o = pal_q;
  assign count_now_o     = count_out_q;
  assign full_flag_o     = full_q;
  assign empty_flag_o    = empty_q;

endmodule

`default_nettype wire

/* tb/stack_with_palindrome_check_core_test.sv */
`timescale 1ns / 1ps

module stack_with_palindrome_check_core_test;
  import stkpal_pkg::*;

  localparam int unsigned StackDepth = DepthDefault;
  localparam int RandomItems = 900;
  localparam int IdlePct = 36;
  localparam int HoldCycles = 300;
  localparam int HoldAfter = 150;
  localparam int QuietFrom = 350;
  localparam int QuietTo = 500;
  localparam int DrainCycles = 2 * StackDepth + 16;
  localparam int CycleLimit = 1_000_000;
  // The block gives opcode 3 no name; it is a no-op.
  localparam logic [1:0] OpUnused = 2'd3;

  // One command for the stack, as it travels on the input stream.
  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] val;
  } stack_cmd_t;

  // What the block must answer for one command.
  typedef struct packed {
    status_e     status;
    logic [31:0] popped;
    logic        pal;
    logic [6:0]  count;
    logic        full;
    logic        empty;
  } stack_reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;  // [31:0] push_value
  logic [1:0]  s_axis_tuser = '0;  // [1:0] opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;       // [31:0] popped_value, [32] is_palindrome,
                                   // [39:33] count_now, [40] full_flag,
                                   // [41] empty_flag, [47:42] zero
  logic [1:0]  m_axis_tuser;       // [1:0] status

  stack_with_palindrome_check_core #(
    .DEPTH(StackDepth)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // Commands waiting to go out, and answers owed by the block, oldest first.
  stack_cmd_t   cmd_backlog[$];
  stack_reply_t owed_replies[$];

  // Shadow of the stack as the block should hold it.
  logic [31:0] shadow_store [StackDepth];
  int          shadow_count = 0;

  // Entry count as it will be once every planned command has run; lets the
  // generator steer toward full and empty.
  int plan_count = 0;

  int cmds_sent = 0;
  int replies_seen = 0;
  int error_count = 0;
  int cycle_count = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int n_push = 0, n_pop = 0, n_query = 0, n_unused = 0;
  int n_overflow = 0, n_underflow = 0, n_pal_hit = 0, n_full_query = 0;

  stack_cmd_t   drv_cmd;
  stack_reply_t mon_want;

  // Neither side idles while the sender is inside this window.
  wire quiet_span = (cmds_sent >= QuietFrom) && (cmds_sent < QuietTo);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (error_count < 40) begin
      $display("MISMATCH reply %0d %s: got %h, want %h", replies_seen, what, got, want);
    end
    error_count++;
  endtask

  // Run one accepted command against the shadow stack and queue its answer.
  function automatic void apply_stack_op(input logic [1:0] op, input logic [31:0] val);
    stack_reply_t r;
    int lo;
    int hi;
    r.status = STAT_OK;
    r.popped = '0;
    r.pal = 1'b0;
    case (op)
      OP_PUSH: begin
        n_push++;
        if (shadow_count >= StackDepth) begin
          r.status = STAT_OVERFLOW;
          n_overflow++;
        end else begin
          shadow_store[shadow_count] = val;
          shadow_count++;
        end
      end
      OP_POP: begin
        n_pop++;
        if (shadow_count == 0) begin
          r.status = STAT_UNDERFLOW;
          n_underflow++;
        end else begin
          shadow_count--;
          r.popped = shadow_store[shadow_count];
        end
      end
      OP_QUERY: begin
        n_query++;
        if (shadow_count == StackDepth) n_full_query++;
        // Empty stack never counts as a palindrome.
        if (shadow_count != 0) begin
          r.pal = 1'b1;
          lo = 0;
          hi = shadow_count - 1;
          while (lo < hi) begin
            if (shadow_store[lo] != shadow_store[hi]) r.pal = 1'b0;
            lo++;
            hi--;
          end
        end
        if (r.pal) n_pal_hit++;
      end
      default: n_unused++;
    endcase
    r.count = 7'(shadow_count);
    r.full = (shadow_count == StackDepth);
    r.empty = (shadow_count == 0);
    owed_replies.push_back(r);
  endfunction

  task automatic plan_cmd(input logic [1:0] op, input logic [31:0] val);
    stack_cmd_t c;
    c.op = op;
    c.val = val;
    cmd_backlog.push_back(c);
    if (op == OP_PUSH && plan_count < StackDepth) plan_count++;
    else if (op == OP_POP && plan_count > 0) plan_count--;
  endtask

  // Pop everything planned so far, plus some pops on the empty stack.
  task automatic plan_drain(input int extra);
    int n;
    n = plan_count + extra;
    repeat (n) plan_cmd(OP_POP, $urandom);
  endtask

  // Narrow words come from a tiny pool so that mirrored entries match often.
  function automatic logic [31:0] pick_word(input bit narrow);
    if (!narrow) return $urandom;
    case ($urandom_range(0, 4))
      0: return 32'h0000_0000;
      1: return 32'h0000_0001;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  task automatic plan_directed();
    plan_cmd(OP_POP, 32'hFFFF_FFFF);     // underflow on empty stack
    plan_cmd(OP_QUERY, 32'h0);           // query on empty stack
    plan_cmd(OpUnused, 32'hA5A5_A5A5);   // unused opcode while empty
    plan_cmd(OP_PUSH, 32'h8000_0000);
    plan_cmd(OP_QUERY, 32'hFFFF_FFFF);   // single entry is symmetric
    plan_cmd(OP_PUSH, 32'h7FFF_FFFF);
    plan_cmd(OP_QUERY, 32'h0);
    plan_cmd(OP_PUSH, 32'h8000_0000);
    plan_cmd(OP_QUERY, 32'h0);           // odd length, symmetric
    plan_cmd(OpUnused, 32'hFFFF_FFFF);   // unused opcode on a held stack
    plan_cmd(OP_POP, 32'h0);
    plan_cmd(OP_POP, 32'h5555_5555);
    plan_cmd(OP_POP, 32'h0);
    plan_cmd(OP_POP, 32'h0);             // back to underflow
    plan_cmd(OP_PUSH, 32'h0000_0000);
    plan_cmd(OP_PUSH, 32'hFFFF_FFFF);
    plan_cmd(OP_PUSH, 32'hFFFF_FFFF);
    plan_cmd(OP_PUSH, 32'h0000_0000);
    plan_cmd(OP_QUERY, 32'h0);           // even length, symmetric
    plan_cmd(OP_PUSH, 32'h0000_0001);
    plan_cmd(OP_QUERY, 32'h0);           // one odd entry breaks it
    plan_cmd(OP_POP, 32'h0);
  endtask

  task automatic plan_random(input int stop_at);
    logic [31:0] mirror_vals [StackDepth];
    int kind;
    int half;
    int pos;
    int r;
    bit narrow;
    bit flaw;
    while (cmd_backlog.size() < stop_at) begin
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        // Mirrored run, sometimes on top of what is already held and
        // sometimes with one flipped bit.
        if ($urandom_range(0, 1)) plan_drain($urandom_range(0, 1));
        half = $urandom_range(0, 7);
        narrow = $urandom_range(0, 1);
        flaw = (kind >= 35) && (half > 0);
        pos = (half > 0) ? $urandom_range(0, half - 1) : 0;
        for (int k = 0; k < half; k++) begin
          mirror_vals[k] = pick_word(narrow);
          plan_cmd(OP_PUSH, mirror_vals[k]);
        end
        if ($urandom_range(0, 1)) plan_cmd(OP_PUSH, pick_word(narrow));
        for (int k = half - 1; k >= 0; k--) begin
          if (flaw && k == pos) begin
            plan_cmd(OP_PUSH, mirror_vals[k] ^ (32'h1 << $urandom_range(0, 31)));
          end else begin
            plan_cmd(OP_PUSH, mirror_vals[k]);
          end
        end
        plan_cmd(OP_QUERY, $urandom);
      end else if (kind < 70) begin
        repeat (10) begin
          r = $urandom_range(0, 99);
          if (r < 45) plan_cmd(OP_PUSH, pick_word($urandom_range(0, 3) == 0));
          else if (r < 80) plan_cmd(OP_POP, $urandom);
          else if (r < 95) plan_cmd(OP_QUERY, $urandom);
          else plan_cmd(OpUnused, $urandom);
        end
      end else if (kind < 76) begin
        // Fill the whole stack symmetrically, push past full, query at full.
        plan_drain(0);
        narrow = $urandom_range(0, 1);
        for (int k = 0; k < StackDepth / 2; k++) begin
          mirror_vals[k] = pick_word(narrow);
          plan_cmd(OP_PUSH, mirror_vals[k]);
        end
        for (int k = StackDepth / 2 - 1; k >= 0; k--) plan_cmd(OP_PUSH, mirror_vals[k]);
        repeat ($urandom_range(1, 3)) plan_cmd(OP_PUSH, $urandom);
        plan_cmd(OP_QUERY, $urandom);
        plan_cmd(OP_POP, $urandom);
        plan_cmd(OP_QUERY, $urandom);
      end else if (kind < 86) begin
        plan_drain($urandom_range(1, 3));
        plan_cmd(OP_QUERY, $urandom);
      end else begin
        repeat (8) plan_cmd(2'($urandom_range(0, 3)), $urandom);
      end
    end
  endtask

  // Driver: advance to the next command once the current one is taken;
  // idle at random outside the quiet window.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        apply_stack_op(s_axis_tuser, s_axis_tdata);
        cmds_sent <= cmds_sent + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (cmd_backlog.size() != 0 && (quiet_span || $urandom_range(0, 99) >= IdlePct)) begin
          drv_cmd = cmd_backlog.pop_front();
          s_axis_tuser <= drv_cmd.op;
          s_axis_tdata <= drv_cmd.val;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Hold off the receiver once for a long stretch so the block backs up.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end else if (!hold_done && cmds_sent >= HoldAfter) begin
        hold_left <= HoldCycles;
        hold_done <= 1'b1;
      end
    end
  end

  // Monitor: check every result transaction against the oldest owed reply.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (owed_replies.size() == 0) begin
          report_mismatch("unexpected result", m_axis_tdata[31:0], '0);
        end else begin
          mon_want = owed_replies.pop_front();
          if (m_axis_tuser !== mon_want.status) begin
            report_mismatch("status", m_axis_tuser, mon_want.status);
          end
          if (m_axis_tdata[31:0] !== mon_want.popped) begin
            report_mismatch("popped_value", m_axis_tdata[31:0], mon_want.popped);
          end
          if (m_axis_tdata[32] !== mon_want.pal) begin
            report_mismatch("is_palindrome", m_axis_tdata[32], mon_want.pal);
          end
          if (m_axis_tdata[39:33] !== mon_want.count) begin
            report_mismatch("count_now", m_axis_tdata[39:33], mon_want.count);
          end
          if (m_axis_tdata[40] !== mon_want.full) begin
            report_mismatch("full_flag", m_axis_tdata[40], mon_want.full);
          end
          if (m_axis_tdata[41] !== mon_want.empty) begin
            report_mismatch("empty_flag", m_axis_tdata[41], mon_want.empty);
          end
          if (m_axis_tdata[47:42] !== '0) begin
            report_mismatch("tdata padding", m_axis_tdata[47:42], '0);
          end
        end
        replies_seen++;
      end
      m_axis_tready <= (hold_left == 0) && (quiet_span || $urandom_range(0, 99) >= IdlePct);
    end
  end

  // Drop the run if it hangs.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d replies owed", cycle_count, owed_replies.size());
      $display("stack_with_palindrome_check_core test failed");
      $finish;
    end
  end

  initial begin
    int directed_n;
    int total_cmds;
    plan_directed();
    directed_n = cmd_backlog.size();
    plan_random(directed_n + RandomItems);
    total_cmds = cmd_backlog.size();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Every planned command answers exactly once.
    while (replies_seen < total_cmds) @(posedge clk_i);
    // Give a stray extra result time to show up.
    repeat (DrainCycles) @(posedge clk_i);
    if (owed_replies.size() != 0) report_mismatch("replies never produced", owed_replies.size(), '0);
    $display("covered %0d commands: %0d push (%0d overflow), %0d pop (%0d underflow),",
             cmds_sent, n_push, n_overflow, n_pop, n_underflow);
    $display("  %0d query (%0d symmetric, %0d at full), %0d unused; %0d mismatches",
             n_query, n_pal_hit, n_full_query, n_unused, error_count);
    if (error_count == 0) begin
      $display("stack_with_palindrome_check_core test passed");
    end else begin
      $display("stack_with_palindrome_check_core test failed");
    end
    $finish;
  end

endmodule
